@@ rtl/lscf_pkg.sv @@
package lscf_pkg;

  // Sample width and the width of the column field of a result.
  localparam int DATA_W = 16;
  localparam int COL_W  = 12;

  // Operations that the controller asks of the datapath.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_SHIFT,
    OP_ACC,
    OP_SQUARE,
    OP_RADICAND,
    OP_ROOT_STEP,
    OP_RW,
    OP_PREP,
    OP_CENTER,
    OP_NUM,
    OP_MAG,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUM,
    ST_SQUARE,
    ST_RADICAND,
    ST_ROOT,
    ST_RW,
    ST_PREP,
    ST_CENTER,
    ST_NUM,
    ST_MAG,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT,
    ST_ERR
  } state_e;

  // Side information that goes with a result.
  typedef struct packed {
    logic [COL_W-1:0] column;
    logic             run_last;
    logic             line_last;
    logic             size_error;
  } meta_t;

  typedef struct packed {
    op_e   op;
    meta_t meta;
  } cmd_t;

  typedef struct packed {
    logic step_last;
    logic out_free;
  } status_t;

endpackage

@@ rtl/local_stat_contrast_filter.sv @@
// Local contrast normalization of scan lines, one signed 16-bit sample per transfer.
// Input channel: in_valid_i / in_stall_o with sample_i and line_end_i; line_end_i marks
// the last sample of a line. Output channel: out_valid_o / out_stall_i with value_o,
// column_o, run_last_o, line_last_o and size_error_o. A transfer happens on a rising
// edge where valid is high and stall is low.
// Each sample shifts a window of 2*HALF_WIDTH+1 samples. Once the window is full, the
// block sums it, forms its square sum and takes an integer square root, then produces
// one to 2*HALF_WIDTH+1 results, one at a time through a shared 17-step divider.
// The input stays stalled while an item is summed, rooted and divided, until its last
// result has been loaded into the output register. The root loop takes ROOT_W steps,
// with ROOT_W = 20 for the default window, and the divider 17 steps per result. After
// the last divider step the controller waits in its emit state until the output
// register is free. Samples before the window fills are taken without a stall; a short
// line ends with one flagged result, loaded into the output register once it is free.
// The output register keeps a finished result while the next sample is taken in; if
// the receiver stalls, the block holds the next result until that register is free.
// Reset clears the control state, the line position and the output valid.
module local_stat_contrast_filter import lscf_pkg::*; #(
  parameter int HALF_WIDTH = 4,
  parameter int MAX_LINE   = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [DATA_W-1:0] sample_i,
  input  logic                     line_end_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] value_o,
  output logic [COL_W-1:0]         column_o,
  output logic                     run_last_o,
  output logic                     line_last_o,
  output logic                     size_error_o
);

  localparam int IDX_W = $clog2(2 * HALF_WIDTH + 1);

  cmd_t             cmd;
  status_t          status;
  logic [IDX_W-1:0] idx;

  // The controller sequences the window sum, the root and one division per result.
  lscf_ctrl #(
    .HALF_WIDTH (HALF_WIDTH),
    .MAX_LINE   (MAX_LINE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .line_end_i (line_end_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd),
    .idx_o      (idx)
  );

  // The datapath holds the window, the arithmetic units and the output register.
  lscf_datapath #(
    .HALF_WIDTH (HALF_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_i),
    .idx_i        (idx),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .value_o      (value_o),
    .column_o     (column_o),
    .run_last_o   (run_last_o),
    .line_last_o  (line_last_o),
    .size_error_o (size_error_o)
  );

endmodule

@@ rtl/lscf_ctrl.sv @@
module lscf_ctrl import lscf_pkg::*; #(
  parameter int HALF_WIDTH = 4,
  parameter int MAX_LINE   = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          line_end_i,
  output logic                          in_stall_o,
  input  status_t                       status_i,
  output cmd_t                          cmd_o,
  output logic [$clog2(2*HALF_WIDTH+1)-1:0] idx_o
);

  localparam int WIN   = 2 * HALF_WIDTH + 1;
  localparam int IDX_W = $clog2(WIN);
  localparam int CNT_W = $clog2(MAX_LINE);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WIN - 1);
  localparam logic [IDX_W-1:0] IDX_MID  = IDX_W'(HALF_WIDTH);
  localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_LINE - 1);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             end_q, end_d;
  logic [IDX_W-1:0] idx_q, idx_d;

  logic [IDX_W-1:0] idx_first;
  logic [IDX_W-1:0] idx_end;
  logic             fin;
  logic [CNT_W-1:0] col_full;

  // The first full window of a line also covers the columns left of its centre;
  // the last one of a line also covers the columns right of it.
  assign idx_first = (int'(n_q) == WIN - 1) ? '0 : IDX_MID;
  assign idx_end   = end_q ? IDX_LAST : IDX_MID;
  assign fin       = (idx_q == idx_end);
  assign col_full  = n_q - CNT_W'(WIN - 1) + CNT_W'(idx_q);

  assign idx_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      n_q     <= '0;
      end_q   <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      end_q   <= end_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    n_d        = n_q;
    end_d      = end_q;
    idx_d      = idx_q;
    in_stall_o = 1'b1;
    cmd_o.op   = OP_NONE;
    cmd_o.meta = '0;

    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_SHIFT;
          n_d      = count_q;
          end_d    = line_end_i;
          idx_d    = '0;
          if (line_end_i) begin
            count_d = '0;
          end else if (count_q != CNT_MAX) begin
            count_d = count_q + 1'b1;
          end
          if (int'(count_q) < WIN - 1) begin
            state_d = line_end_i ? ST_ERR : ST_IDLE;
          end else begin
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        cmd_o.op = OP_ACC;
        if (idx_q == IDX_LAST) begin
          state_d = ST_SQUARE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SQUARE: begin
        cmd_o.op = OP_SQUARE;
        state_d  = ST_RADICAND;
      end
      ST_RADICAND: begin
        cmd_o.op = OP_RADICAND;
        state_d  = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.op = OP_ROOT_STEP;
        if (status_i.step_last) begin
          state_d = ST_RW;
        end
      end
      ST_RW: begin
        cmd_o.op = OP_RW;
        state_d  = ST_PREP;
      end
      ST_PREP: begin
        cmd_o.op = OP_PREP;
        idx_d    = idx_first;
        state_d  = ST_CENTER;
      end
      ST_CENTER: begin
        cmd_o.op = OP_CENTER;
        state_d  = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.op = OP_NUM;
        state_d  = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.op = OP_MAG;
        state_d  = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.op = OP_DIV_INIT;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.op = OP_DIV_STEP;
        if (status_i.step_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.op              = OP_EMIT;
          cmd_o.meta.column     = COL_W'(col_full);
          cmd_o.meta.run_last   = fin;
          cmd_o.meta.line_last  = fin & end_q;
          cmd_o.meta.size_error = 1'b0;
          if (fin) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_CENTER;
          end
        end
      end
      ST_ERR: begin
        if (status_i.out_free) begin
          cmd_o.op              = OP_EMIT;
          cmd_o.meta.column     = COL_W'(n_q);
          cmd_o.meta.run_last   = 1'b1;
          cmd_o.meta.line_last  = 1'b1;
          cmd_o.meta.size_error = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/lscf_datapath.sv @@
module lscf_datapath import lscf_pkg::*; #(
  parameter int HALF_WIDTH = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [DATA_W-1:0]          sample_i,
  input  logic [$clog2(2*HALF_WIDTH+1)-1:0] idx_i,
  input  cmd_t                              cmd_i,
  output status_t                           status_o,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic signed [DATA_W-1:0]          value_o,
  output logic [COL_W-1:0]                  column_o,
  output logic                              run_last_o,
  output logic                              line_last_o,
  output logic                              size_error_o
);

  localparam int WIN     = 2 * HALF_WIDTH + 1;
  localparam int WIN_LOG = $clog2(WIN);
  localparam int S_W     = DATA_W + 1 + WIN_LOG;
  localparam int Q_W     = 2 * DATA_W + WIN_LOG;
  localparam int D_W     = 2 * DATA_W - 1 + 2 * WIN_LOG;
  localparam int RAD_W   = D_W + (D_W % 2);
  localparam int ROOT_W  = RAD_W / 2;
  localparam int RW_W    = ROOT_W + 1;
  localparam int DEN_W   = RW_W + $clog2(2 * WIN + 1);
  localparam int D2_W    = DEN_W + 1;
  localparam int P2_W    = S_W + RW_W + 1;
  localparam int T1_W    = S_W + 2;
  localparam int K50     = 50 * WIN;
  localparam int NUM_W   = S_W + RW_W + $clog2(K50 + 1);
  localparam int N2_W    = NUM_W + 2;
  localparam int QUO_W   = DATA_W + 1;
  localparam int DIV_W   = (N2_W > D2_W + QUO_W) ? N2_W : D2_W + QUO_W;
  localparam int STEP_MX = (ROOT_W > QUO_W) ? ROOT_W : QUO_W;
  localparam int STEP_W  = $clog2(STEP_MX);

  localparam logic [RAD_W-1:0] BIT_INIT = RAD_W'(1) << (RAD_W - 2);
  localparam logic [QUO_W-1:0] POS_MAX  = QUO_W'((1 << (DATA_W - 1)) - 1);
  localparam logic [QUO_W-1:0] NEG_MAX  = QUO_W'(1 << (DATA_W - 1));

  logic signed [DATA_W-1:0] window_q [WIN];
  logic signed [S_W-1:0]    s_q;
  logic [Q_W-1:0]           q_q;
  logic [RAD_W-1:0]         wq_q, ss_q;
  logic [RAD_W-1:0]         v_q, res_q, bit_q;
  logic [RW_W-1:0]          rw_q;
  logic signed [P2_W-1:0]   p2_q;
  logic [DEN_W-1:0]         den_q;
  logic [D2_W-1:0]          den2_q;
  logic signed [T1_W-1:0]   t1_q;
  logic signed [NUM_W-1:0]  num_q;
  logic                     neg_q;
  logic [N2_W-1:0]          n2_q;
  logic [DIV_W-1:0]         rem_q, dsh_q;
  logic [QUO_W-1:0]         quo_q;
  logic                     ovf_q;
  logic [STEP_W-1:0]        step_q;
  logic                     oval_q;

  logic signed [DATA_W-1:0]   zsel;
  logic signed [2*DATA_W-1:0] sq;
  logic signed [2*S_W-1:0]    ss_full;
  logic [RAD_W-1:0]           wq;
  logic [RAD_W:0]             trial;
  logic                       root_ge;
  logic [RW_W-1:0]            rw;
  logic signed [P2_W-1:0]     p2;
  logic [DEN_W-1:0]           den;
  logic signed [T1_W-1:0]     t1;
  logic signed [NUM_W-1:0]    num;
  logic [NUM_W-1:0]           mag;
  logic [N2_W-1:0]            n2;
  logic [DIV_W-1:0]           dsh_init, ovf_lim;
  logic                       div_ge;
  logic [QUO_W-1:0]           quo_neg;
  logic [DATA_W-1:0]          value_sat;

  assign zsel    = window_q[idx_i];
  assign sq      = zsel * zsel;
  assign ss_full = s_q * s_q;
  assign wq      = RAD_W'(q_q) * RAD_W'(WIN);

  // One step of the digit-by-digit square root, two radicand bits per step.
  assign trial   = {1'b0, res_q} + {1'b0, bit_q};
  assign root_ge = ({1'b0, v_q} >= trial);

  assign rw  = RW_W'(res_q) + RW_W'(2 * WIN);
  assign p2  = s_q * $signed({1'b0, rw_q});
  assign den = DEN_W'(rw_q) * DEN_W'(2 * WIN);
  assign t1  = T1_W'(zsel) * T1_W'(WIN) - T1_W'(s_q);
  assign num = NUM_W'(t1_q) * NUM_W'(K50) + NUM_W'(p2_q);
  assign mag = num_q[NUM_W-1] ? $unsigned(-num_q) : $unsigned(num_q);
  assign n2  = (N2_W'(mag) << 1) + N2_W'(den_q);

  assign dsh_init = DIV_W'(den2_q) << (QUO_W - 1);
  assign ovf_lim  = DIV_W'(den2_q) << QUO_W;
  assign div_ge   = (rem_q >= dsh_q);

  assign quo_neg = QUO_W'(0) - quo_q;

  always_comb begin
    if (neg_q) begin
      value_sat = (ovf_q || quo_q > NEG_MAX) ? DATA_W'(NEG_MAX) : quo_neg[DATA_W-1:0];
    end else begin
      value_sat = (ovf_q || quo_q > POS_MAX) ? DATA_W'(POS_MAX) : quo_q[DATA_W-1:0];
    end
  end

  assign status_o.step_last = (step_q == '0);
  assign status_o.out_free  = !oval_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      oval_q <= 1'b0;
    end else begin
      if (cmd_i.op == OP_RADICAND) begin
        step_q <= STEP_W'(ROOT_W - 1);
      end else if (cmd_i.op == OP_DIV_INIT) begin
        step_q <= STEP_W'(QUO_W - 1);
      end else if (cmd_i.op == OP_ROOT_STEP || cmd_i.op == OP_DIV_STEP) begin
        step_q <= step_q - 1'b1;
      end
      if (cmd_i.op == OP_EMIT) begin
        oval_q <= 1'b1;
      end else if (!out_stall_i) begin
        oval_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_SHIFT: begin
        for (int i = 0; i < WIN - 1; i++) begin
          window_q[i] <= window_q[i+1];
        end
        window_q[WIN-1] <= sample_i;
        s_q <= '0;
        q_q <= '0;
      end
      OP_ACC: begin
        s_q <= s_q + S_W'(zsel);
        q_q <= q_q + Q_W'($unsigned(sq));
      end
      OP_SQUARE: begin
        wq_q <= wq;
        ss_q <= RAD_W'(ss_full);
      end
      OP_RADICAND: begin
        v_q   <= wq_q - ss_q;
        res_q <= '0;
        bit_q <= BIT_INIT;
      end
      OP_ROOT_STEP: begin
        if (root_ge) begin
          v_q   <= v_q - trial[RAD_W-1:0];
          res_q <= (res_q >> 1) + bit_q;
        end else begin
          res_q <= res_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      OP_RW: begin
        rw_q <= rw;
      end
      OP_PREP: begin
        p2_q   <= p2;
        den_q  <= den;
        den2_q <= {den, 1'b0};
      end
      OP_CENTER: begin
        t1_q <= t1;
      end
      OP_NUM: begin
        num_q <= num;
      end
      OP_MAG: begin
        neg_q <= num_q[NUM_W-1];
        n2_q  <= n2;
      end
      OP_DIV_INIT: begin
        rem_q <= DIV_W'(n2_q);
        dsh_q <= dsh_init;
        quo_q <= '0;
        ovf_q <= (DIV_W'(n2_q) >= ovf_lim);
      end
      OP_DIV_STEP: begin
        if (div_ge) begin
          rem_q <= rem_q - dsh_q;
        end
        quo_q <= {quo_q[QUO_W-2:0], div_ge};
        dsh_q <= dsh_q >> 1;
      end
      OP_EMIT: begin
        value_o      <= cmd_i.meta.size_error ? '0 : $signed(value_sat);
        column_o     <= cmd_i.meta.column;
        run_last_o   <= cmd_i.meta.run_last;
        line_last_o  <= cmd_i.meta.line_last;
        size_error_o <= cmd_i.meta.size_error;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = oval_q;

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

module tb import lscf_pkg::*;;

  // Block configuration. The window is centered on the sample under test, so
  // a full window holds 2*HALF_WIDTH+1 samples of the same line.
  localparam int HALF_WIDTH = 4;
  localparam int MAX_LINE   = 4096;
  localparam int WIN        = 2 * HALF_WIDTH + 1;

  // Worst case per item is nine results, each with its own division after the root
  // loop. LIMIT bounds the whole run, idling on both sides included, and stops it
  // if it hangs.
  localparam int LIMIT        = 500_000;
  localparam int TAIL         = 300;
  localparam int RANDOM_ITEMS = 140;

  typedef logic signed [DATA_W-1:0] sample_t;

  // One result as the output channel presents it.
  typedef struct packed {
    sample_t value;
    meta_t   meta;
  } result_t;

  // How the samples of a random line are shaped.
  typedef enum int {
    SHAPE_NOISE,   // full-range random samples, large spread
    SHAPE_RIPPLE,  // small noise around a random level, small spread
    SHAPE_FLAT,    // one level repeated, zero spread
    SHAPE_RAIL     // only the two extremes of the sample range
  } shape_e;

  // The scoreboard carries its own copy of the window and the line position.
  // Each accepted transfer on the input is turned into the results it must
  // cause, which then wait in order for the output channel.
  class contrast_scoreboard;
    sample_t     window[WIN];
    int unsigned line_pos;
    result_t     due[$];
    int unsigned mismatches;

    function new();
      foreach (window[i]) window[i] = '0;
      line_pos   = 0;
      mismatches = 0;
    endfunction

    // Floor of the square root, built one bit at a time from the top.
    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= v) root = trial;
      end
      return root;
    endfunction

    // Contrast-normalized center value: 25*(z-mean)/(std+2) + mean/2, with
    // std = r/WIN, rounded half away from zero and clamped to 16 bits.
    function sample_t normalize_center(longint z, longint s, longint r);
      longint rw, num, den, mag, q;
      rw  = r + 2 * WIN;
      num = 50 * WIN * (WIN * z - s) + s * rw;
      den = 2 * WIN * rw;
      mag = (num < 0) ? -num : num;
      q   = (2 * mag + den) / (2 * den);
      if (num < 0) q = (q > 32768) ? -32768 : -q;
      else if (q > 32767) q = 32767;
      return sample_t'(q);
    endfunction

    function void expect_result(sample_t value, int unsigned col, bit run_end,
                                bit line_end, bit size_err);
      result_t r;
      r.value           = value;
      r.meta.column     = COL_W'(col);
      r.meta.run_last   = run_end;
      r.meta.line_last  = line_end;
      r.meta.size_error = size_err;
      due.push_back(r);
    endfunction

    function void note_input(sample_t smp, logic last);
      int unsigned     n, m;
      longint          s, sq, v;
      longint unsigned r;
      int              first, stop;
      n = line_pos;
      m = n + 1;
      for (int i = 0; i < WIN - 1; i++) window[i] = window[i + 1];
      window[WIN - 1] = smp;
      line_pos = (n + 1 > MAX_LINE - 1) ? MAX_LINE - 1 : n + 1;
      if (last) line_pos = 0;

      // A line that ends before the window fills gives a single flagged result.
      if (m < WIN) begin
        if (last) expect_result('0, n, 1'b1, 1'b1, 1'b1);
        return;
      end

      s  = 0;
      sq = 0;
      for (int i = 0; i < WIN; i++) begin
        v  = window[i];
        s  += v;
        sq += v * v;
      end
      r = int_sqrt(longint'(WIN) * sq - s * s);

      // The newest sample is column n. The first full window also covers the
      // leading edge columns, and the end of a line flushes the trailing ones.
      first = (m == WIN) ? 0 : HALF_WIDTH;
      stop  = last ? WIN - 1 : HALF_WIDTH;
      for (int i = first; i <= stop; i++)
        expect_result(normalize_center(window[i], s, r), n - (WIN - 1 - i),
                      i == stop, (i == stop) && last, 1'b0);
    endfunction

    function void report(string why, result_t want, result_t got);
      mismatches++;
      if (mismatches <= 10)
        $display({"tb: %s: want value %0d col %0d run %b line %b err %b,",
                  " got value %0d col %0d run %b line %b err %b"},
                 why, want.value, want.meta.column, want.meta.run_last,
                 want.meta.line_last, want.meta.size_error, got.value,
                 got.meta.column, got.meta.run_last, got.meta.line_last,
                 got.meta.size_error);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due.size() == 0) begin
        report("result with nothing due", '0, got);
        return;
      end
      want = due.pop_front();
      if (got.value !== want.value || got.meta.column !== want.meta.column ||
          got.meta.run_last !== want.meta.run_last ||
          got.meta.line_last !== want.meta.line_last ||
          got.meta.size_error !== want.meta.size_error)
        report("mismatch", want, got);
    endfunction
  endclass

  logic    clk_i       = 1'b0;
  logic    rst_ni      = 1'b0;
  logic    in_valid_i  = 1'b0;
  logic    in_stall_o;
  sample_t sample_i    = '0;
  logic    line_end_i  = 1'b0;
  logic    out_valid_o;
  logic    out_stall_i = 1'b0;
  sample_t value_o;
  logic [COL_W-1:0] column_o;
  logic    run_last_o;
  logic    line_last_o;
  logic    size_error_o;

  contrast_scoreboard board;
  result_t seen;
  bit      calm = 1'b0;   // while set, neither side idles
  int      sent = 0;      // input transfers so far
  int      cycles = 0;

  local_stat_contrast_filter #(
    .HALF_WIDTH(HALF_WIDTH),
    .MAX_LINE  (MAX_LINE)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .line_end_i  (line_end_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .column_o    (column_o),
    .run_last_o  (run_last_o),
    .line_last_o (line_last_o),
    .size_error_o(size_error_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The run is cut off if it hangs, for example when results stop coming.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // The receiver stalls about a third of the time, except in calm stretches.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 32);
  end

  // Every transfer on the output is checked against the oldest result due.
  // Signals are read at the edge, before this edge's updates take effect.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.value           = value_o;
      seen.meta.column     = column_o;
      seen.meta.run_last   = run_last_o;
      seen.meta.line_last  = line_last_o;
      seen.meta.size_error = size_error_o;
      board.check_result(seen);
    end
  end

  // Offers one sample and returns at the edge where it is taken. Valid is left
  // high, so back-to-back samples keep it up with a single assignment per edge.
  task automatic push_sample(sample_t smp, logic last);
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    sample_i   <= smp;
    line_end_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    board.note_input(smp, last);
    sent++;
  endtask

  task automatic send_line(int len, shape_e shape);
    sample_t level, smp;
    level = sample_t'($urandom);
    for (int k = 0; k < len; k++) begin
      case (shape)
        SHAPE_NOISE:  smp = sample_t'($urandom);
        SHAPE_RIPPLE: smp = level + sample_t'($urandom_range(64)) - 16'sd32;
        SHAPE_FLAT:   smp = level;
        default:      smp = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      endcase
      push_sample(smp, k == len - 1);
    end
  endtask

  initial begin
    int start, len;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. A line of one sample and a line of eight both end before
    // the window fills and must give one flagged result each.
    push_sample(16'sh8000, 1'b1);
    for (int k = 0; k < WIN - 1; k++)
      push_sample(k[0] ? 16'sh7fff : 16'sh8000, k == WIN - 2);
    // A line of exactly one window: all nine columns come out on its end,
    // here with the largest spread the samples allow.
    for (int k = 0; k < WIN; k++)
      push_sample(k[0] ? 16'sh8000 : 16'sh7fff, k == WIN - 1);
    // A single outlier at the window center against a flat zero background.
    for (int k = 0; k < WIN; k++)
      push_sample(k == HALF_WIDTH ? 16'sh7fff : 16'sh0000, k == WIN - 1);

    // Random lines. Most are long enough to fill the window; some are short,
    // and some are exactly one window long to produce the largest bursts.
    // A stretch in the middle runs with no idling on either side.
    start = sent;
    while (sent - start < RANDOM_ITEMS) begin
      calm = (sent - start >= 50) && (sent - start < 100);
      if ($urandom_range(99) < 15) len = $urandom_range(WIN - 1, 1);
      else if ($urandom_range(99) < 15) len = WIN;
      else len = $urandom_range(28, WIN + 1);
      send_line(len, shape_e'($urandom_range(3)));
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    // Wait for every result due, then a little longer for strays.
    while (board.due.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (board.mismatches == 0 && board.due.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
rtl/lscf_pkg.sv
rtl/lscf_ctrl.sv
rtl/lscf_datapath.sv
rtl/local_stat_contrast_filter.sv
tb/sv/tb.sv
